// ----- sv/mt_pkg.sv -----
package mt_pkg;

  localparam int unsigned TableWords = 624;
  localparam int unsigned AddrW      = $clog2(TableWords);
  localparam int unsigned CntW       = $clog2(TableWords + 2);

  localparam logic [CntW-1:0] TABLE_END   = CntW'(TableWords);
  localparam logic [CntW-1:0] FAST_FILL   = CntW'(398);
  localparam logic [CntW-1:0] LOW_SPLIT   = CntW'(227);
  localparam logic [CntW-1:0] SHIFT_POS   = CntW'(397);

  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] UPPER_BIT    = 32'h8000_0000;
  localparam logic [31:0] LOWER_BITS   = 32'h7FFF_FFFF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;

  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_RD_FAR,
    ST_TWIST,
    ST_FILL,
    ST_PUT
  } mt_state_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- sv/mersenne_twister_generator.sv -----
// MT19937 32-bit generator. A transfer with in_tuser = 0 seeds the 624-word
// table from in_tdata and gives no result; in_tuser = 1 draws one tempered
// word on out_tdata. A seed writes word 0 and fills words 1..397 through
// the shared 32x32 multiplier; the remaining words are filled one per draw
// over the first 226 draws. A draw takes three reads of the table's one
// read port, one twist write, one optional lazy-fill write and the output
// load, which waits out any output stall. A draw before any seed first
// seeds the whole table with 5489. in_tready is high only while the
// sequencer is idle; the output register lets a new item enter while a
// result still waits.
module mersenne_twister_generator
  import mt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // seed_value
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // random_word
);

  mt_state_t state_r, state_nxt;

  logic [31:0] table_mem [TableWords];
  logic [31:0] rd_data_r;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [31:0]      wr_data;

  logic [CntW-1:0] idx_r, idx_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic            full_r, full_nxt;
  logic [31:0]     prev_r, prev_nxt;
  logic [31:0]     prod_r;
  logic [31:0]     cur_r, cur_nxt;
  logic [31:0]     nxt_r, nxt_nxt;
  logic [31:0]     y_r, y_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_data_r, out_data_nxt;

  logic [CntW-1:0] nxt_idx;
  logic [CntW-1:0] far_idx;
  logic [CntW-1:0] fill_end;
  logic [31:0]     init_word;
  logic [31:0]     twisted;
  logic            in_fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign nxt_idx  = (idx_r + 1'b1 < TABLE_END) ? idx_r + 1'b1 : '0;
  assign far_idx  = (idx_r < LOW_SPLIT) ? idx_r + SHIFT_POS : idx_r - LOW_SPLIT;
  assign fill_end = full_r ? TABLE_END : FAST_FILL;

  // shared recurrence adder: previous product plus the word index
  assign init_word = prod_r + {{(32-CntW){1'b0}}, fill_r};

  assign twisted = rd_data_r
                 ^ (((cur_r & UPPER_BIT) | (nxt_r & LOWER_BITS)) >> 1)
                 ^ (nxt_r[0] ? TWIST_MATRIX : 32'd0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= table_mem[rd_addr];
  end

  // the one multiplier, fed from the last written init word
  always_ff @(posedge clk) begin
    prod_r <= INIT_MULT * (prev_r ^ (prev_r >> 30));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= TABLE_END + 1'b1;
      fill_r      <= TABLE_END;
      full_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fill_r      <= fill_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    full_nxt      = full_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    y_nxt         = y_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_addr       = idx_r[AddrW-1:0];
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = in_tdata;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == ACT_SEED) begin
            wr_en     = 1'b1;
            wr_data   = in_tdata;
            prev_nxt  = in_tdata;
            fill_nxt  = CntW'(1);
            full_nxt  = 1'b0;
            idx_nxt   = TABLE_END;
            state_nxt = ST_SEED_MUL;
          end else if (idx_r > TABLE_END) begin
            // never seeded: full table from the default seed, then draw
            wr_en     = 1'b1;
            wr_data   = DEFAULT_SEED;
            prev_nxt  = DEFAULT_SEED;
            fill_nxt  = CntW'(1);
            full_nxt  = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_SEED_MUL;
          end else begin
            if (idx_r == TABLE_END) begin
              idx_nxt = '0;
            end
            state_nxt = ST_RD_CUR;
          end
        end
      end
      ST_SEED_MUL: begin
        if (fill_r == fill_end) begin
          state_nxt = full_r ? ST_RD_CUR : ST_IDLE;
        end else begin
          state_nxt = ST_SEED_WR;
        end
      end
      ST_SEED_WR: begin
        wr_en     = 1'b1;
        wr_addr   = fill_r[AddrW-1:0];
        wr_data   = init_word;
        prev_nxt  = init_word;
        fill_nxt  = fill_r + 1'b1;
        state_nxt = ST_SEED_MUL;
      end
      ST_RD_CUR: begin
        rd_addr   = idx_r[AddrW-1:0];
        state_nxt = ST_RD_NXT;
      end
      ST_RD_NXT: begin
        rd_addr   = nxt_idx[AddrW-1:0];
        cur_nxt   = rd_data_r;
        state_nxt = ST_RD_FAR;
      end
      ST_RD_FAR: begin
        rd_addr   = far_idx[AddrW-1:0];
        nxt_nxt   = rd_data_r;
        state_nxt = ST_TWIST;
      end
      ST_TWIST: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[AddrW-1:0];
        wr_data   = twisted;
        y_nxt     = twisted;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        // lazy fill of the upper table words during the early draws
        if (idx_r < LOW_SPLIT && fill_r < TABLE_END) begin
          wr_en    = 1'b1;
          wr_addr  = fill_r[AddrW-1:0];
          wr_data  = init_word;
          prev_nxt = init_word;
          fill_nxt = fill_r + 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = temper(y_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
